@@ design/msae_pkg.sv @@
// Package for the SPECIAL-group execute block.
// Holds command, status and function codes, register index constants, the JALR link offset,
// the register file depth, the word type and a sign-extension helper. No dependencies.
package msae_pkg;

  // Command codes of an input request.
  localparam logic [1:0] CMD_EXEC  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Status codes of a result.
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_BREAK   = 2'd2;

  // Direct access indexes of HI and LO.
  localparam logic [5:0] IDX_HI = 6'd32;
  localparam logic [5:0] IDX_LO = 6'd33;

  // Link offset for JALR.
  localparam logic [63:0] LINK_OFFSET = 64'd4;

  // SPECIAL function codes.
  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_SLLV  = 6'h04;
  localparam logic [5:0] FN_SRLV  = 6'h06;
  localparam logic [5:0] FN_JR    = 6'h08;
  localparam logic [5:0] FN_JALR  = 6'h09;
  localparam logic [5:0] FN_MOVZ  = 6'h0a;
  localparam logic [5:0] FN_MOVN  = 6'h0b;
  localparam logic [5:0] FN_BREAK = 6'h0d;
  localparam logic [5:0] FN_MFHI  = 6'h10;
  localparam logic [5:0] FN_MTHI  = 6'h11;
  localparam logic [5:0] FN_MFLO  = 6'h12;
  localparam logic [5:0] FN_MTLO  = 6'h13;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUBU  = 6'h23;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_SLT   = 6'h2a;
  localparam logic [5:0] FN_SLTU  = 6'h2b;

  // General register file geometry.
  localparam int unsigned GPR_DEPTH = 32;

  typedef logic [63:0] word_t;

  // Sign-extend a 32-bit result to 64 bits.
  function automatic word_t sext32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

endpackage

@@ design/mips_special_alu_execute.sv @@
// Top level of the SPECIAL-group execute block with direct register access.
// Depends on msae_pkg for codes, constants and the sign-extension helper.
//
//  Channel | Direction | Handshake          | Payload
//  in_     | input     | in_valid/in_stall  | command, instruction, pc, reg_index, reg_value
//  out_    | output    | out_valid/out_stall| status, jump_taken, jump_target, delay_slot_pc,
//          |           |                    | reg_written, written_index, written_value,
//          |           |                    | read_value
//
// One request is accepted per cycle while in_stall is low. Acceptance captures the request
// and the registered register file reads at rs and rt (or the direct read index) in the
// execute stage registers; the execute stage then executes, writes back and loads the output
// register once the output register is free or draining.
// A write-back in the same cycle as a read is forwarded to the execute stage operand.
// Reset (rst_n low, synchronous) clears GPR valid bits, HI, LO and all valids.
// When the output is stalled and full, the execute stage holds and in_stall rises.
module mips_special_alu_execute (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_instruction,
  input  logic [63:0] in_pc,
  input  logic [5:0]  in_reg_index,
  input  logic [63:0] in_reg_value,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_jump_taken,
  output logic [63:0] out_jump_target,
  output logic [63:0] out_delay_slot_pc,
  output logic        out_reg_written,
  output logic [4:0]  out_written_index,
  output logic [63:0] out_written_value,
  output logic [63:0] out_read_value
);

  // Register file storage and per-entry valid bits.
  msae_pkg::word_t gpr_mem [msae_pkg::GPR_DEPTH];
  logic [31:0]     gpr_ok_r;
  msae_pkg::word_t hi_r;
  msae_pkg::word_t lo_r;

  // Execute stage registers.
  logic            s1_v_r;
  logic [1:0]      s1_cmd_r;
  logic [31:0]     s1_ins_r;
  logic [63:0]     s1_pc_r;
  logic [5:0]      s1_ridx_r;
  logic [63:0]     s1_rval_r;
  msae_pkg::word_t rs_raw_r;
  msae_pkg::word_t rt_raw_r;
  logic            rs_ok_r;
  logic            rt_ok_r;
  logic            rs_fwd_r;
  logic            rt_fwd_r;
  msae_pkg::word_t fwd_val_r;

  // Output registers.
  logic            out_v_r;
  logic [1:0]      res_status_r;
  logic            res_jump_r;
  logic [63:0]     res_target_r;
  logic [63:0]     res_dspc_r;
  logic            res_wr_r;
  logic [4:0]      res_widx_r;
  logic [63:0]     res_wval_r;
  logic [63:0]     res_rdval_r;

  // Handshake control.
  logic            s1_go;
  logic            in_acc;
  logic [4:0]      rd_addr_a;
  logic [4:0]      rd_addr_b;

  // Execute-stage decode and results.
  logic [5:0]      fn;
  logic [4:0]      sa;
  logic [4:0]      rd;
  msae_pkg::word_t rs_val;
  msae_pkg::word_t rt_val;
  logic [31:0]     vs;
  logic [31:0]     vt;
  logic [63:0]     vt_dbl;
  logic            wr_req;
  logic [4:0]      wr_idx;
  msae_pkg::word_t wr_val;
  logic            gpr_we;
  logic            hi_we;
  logic            lo_we;
  msae_pkg::word_t hilo_val;
  logic [1:0]      res_status_nxt;
  logic            res_jump_nxt;
  logic [63:0]     res_target_nxt;
  logic [63:0]     res_dspc_nxt;
  logic [63:0]     res_rdval_nxt;

  // The execute stage moves on when the output register is free or draining.
  assign s1_go    = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall = s1_v_r && !s1_go;
  assign in_acc   = in_valid && !in_stall;

  // Port A serves rs, or the direct read index; port B serves rt.
  assign rd_addr_a = (in_command == msae_pkg::CMD_READ) ? in_reg_index[4:0]
                                                        : in_instruction[25:21];
  assign rd_addr_b = in_instruction[20:16];

  // Register file write and registered reads.
  always_ff @(posedge clk) begin
    if (gpr_we) begin
      gpr_mem[wr_idx] <= wr_val;
    end
    if (in_acc) begin
      rs_raw_r <= gpr_mem[rd_addr_a];
      rt_raw_r <= gpr_mem[rd_addr_b];
    end
  end

  // Valid bits: an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gpr_ok_r <= '0;
    end else if (gpr_we) begin
      gpr_ok_r[wr_idx] <= 1'b1;
    end
  end

  // Execute stage capture, with forwarding of a write-back in the same cycle.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r  <= in_command;
      s1_ins_r  <= in_instruction;
      s1_pc_r   <= in_pc;
      s1_ridx_r <= in_reg_index;
      s1_rval_r <= in_reg_value;
      rs_ok_r   <= gpr_ok_r[rd_addr_a];
      rt_ok_r   <= gpr_ok_r[rd_addr_b];
      rs_fwd_r  <= gpr_we && (wr_idx == rd_addr_a);
      rt_fwd_r  <= gpr_we && (wr_idx == rd_addr_b);
      fwd_val_r <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
    end
  end

  // Operand selection after the registered read.
  assign rs_val = rs_fwd_r ? fwd_val_r : (rs_ok_r ? rs_raw_r : '0);
  assign rt_val = rt_fwd_r ? fwd_val_r : (rt_ok_r ? rt_raw_r : '0);
  assign vs     = rs_val[31:0];
  assign vt     = rt_val[31:0];
  assign vt_dbl = {vt, vt};
  assign fn     = s1_ins_r[5:0];
  assign sa     = s1_ins_r[10:6];
  assign rd     = s1_ins_r[15:11];

  // Command and function decode with result values.
  always_comb begin
    wr_req         = 1'b0;
    wr_idx         = rd;
    wr_val         = '0;
    hi_we          = 1'b0;
    lo_we          = 1'b0;
    hilo_val       = rs_val;
    res_status_nxt = msae_pkg::ST_DONE;
    res_jump_nxt   = 1'b0;
    res_target_nxt = '0;
    res_dspc_nxt   = '0;
    res_rdval_nxt  = '0;
    unique case (s1_cmd_r)
      msae_pkg::CMD_WRITE: begin
        wr_idx   = s1_ridx_r[4:0];
        wr_val   = s1_rval_r;
        hilo_val = s1_rval_r;
        wr_req   = (s1_ridx_r[5] == 1'b0);
        hi_we    = (s1_ridx_r == msae_pkg::IDX_HI);
        lo_we    = (s1_ridx_r == msae_pkg::IDX_LO);
      end
      msae_pkg::CMD_READ: begin
        if (s1_ridx_r[5] == 1'b0) begin
          res_rdval_nxt = rs_val;
        end else if (s1_ridx_r == msae_pkg::IDX_HI) begin
          res_rdval_nxt = hi_r;
        end else if (s1_ridx_r == msae_pkg::IDX_LO) begin
          res_rdval_nxt = lo_r;
        end
      end
      msae_pkg::CMD_EXEC: begin
        unique case (fn)
          msae_pkg::FN_SLL: begin
            wr_req = 1'b1;
            wr_val = msae_pkg::sext32(vt << sa);
          end
          msae_pkg::FN_SRL: begin
            wr_req = 1'b1;
            if (s1_ins_r[21]) begin
              wr_val = msae_pkg::sext32(32'(vt_dbl >> sa));
            end else begin
              wr_val = msae_pkg::sext32(vt >> sa);
            end
          end
          msae_pkg::FN_SRA: begin
            wr_req = 1'b1;
            wr_val = msae_pkg::sext32(32'($signed(vt) >>> sa));
          end
          msae_pkg::FN_SLLV: begin
            wr_req = 1'b1;
            wr_val = msae_pkg::sext32(vt << vs[4:0]);
          end
          msae_pkg::FN_SRLV: begin
            wr_req = 1'b1;
            if (s1_ins_r[6]) begin
              wr_val = msae_pkg::sext32(32'(vt_dbl >> vs[4:0]));
            end else begin
              wr_val = msae_pkg::sext32(vt >> vs[4:0]);
            end
          end
          msae_pkg::FN_JR: begin
            res_jump_nxt   = 1'b1;
            res_target_nxt = rs_val;
            res_dspc_nxt   = s1_pc_r;
          end
          msae_pkg::FN_JALR: begin
            res_jump_nxt   = 1'b1;
            res_target_nxt = rs_val;
            res_dspc_nxt   = s1_pc_r;
            wr_req         = 1'b1;
            wr_val         = s1_pc_r + msae_pkg::LINK_OFFSET;
          end
          msae_pkg::FN_MOVZ: begin
            wr_req = (vt == 32'd0);
            wr_val = msae_pkg::sext32(vs);
          end
          msae_pkg::FN_MOVN: begin
            wr_req = (vt != 32'd0);
            wr_val = msae_pkg::sext32(vs);
          end
          msae_pkg::FN_BREAK: begin
            res_status_nxt = msae_pkg::ST_BREAK;
          end
          msae_pkg::FN_MFHI: begin
            wr_req = 1'b1;
            wr_val = msae_pkg::sext32(hi_r[31:0]);
          end
          msae_pkg::FN_MTHI: begin
            hi_we = 1'b1;
          end
          msae_pkg::FN_MFLO: begin
            wr_req = 1'b1;
            wr_val = msae_pkg::sext32(lo_r[31:0]);
          end
          msae_pkg::FN_MTLO: begin
            lo_we = 1'b1;
          end
          msae_pkg::FN_ADDU: begin
            wr_req = 1'b1;
            wr_val = msae_pkg::sext32(vs + vt);
          end
          msae_pkg::FN_SUBU: begin
            wr_req = 1'b1;
            wr_val = msae_pkg::sext32(vs - vt);
          end
          msae_pkg::FN_AND: begin
            wr_req = 1'b1;
            wr_val = msae_pkg::sext32(vs & vt);
          end
          msae_pkg::FN_OR: begin
            wr_req = 1'b1;
            wr_val = msae_pkg::sext32(vs | vt);
          end
          msae_pkg::FN_XOR: begin
            wr_req = 1'b1;
            wr_val = msae_pkg::sext32(vs ^ vt);
          end
          msae_pkg::FN_SLT: begin
            wr_req = 1'b1;
            wr_val = {63'd0, ($signed(vs) < $signed(vt))};
          end
          msae_pkg::FN_SLTU: begin
            wr_req = 1'b1;
            wr_val = {63'd0, (vs < vt)};
          end
          default: begin
            res_status_nxt = msae_pkg::ST_UNKNOWN;
          end
        endcase
      end
      default: begin
        res_status_nxt = msae_pkg::ST_UNKNOWN;
      end
    endcase
  end

  // Register zero is never written; all writes happen once, as the stage moves on.
  assign gpr_we = s1_go && wr_req && (wr_idx != 5'd0);

  // HI and LO registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_r <= '0;
      lo_r <= '0;
    end else if (s1_go) begin
      if (hi_we) begin
        hi_r <= hilo_val;
      end
      if (lo_we) begin
        lo_r <= hilo_val;
      end
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_go) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (s1_go) begin
      res_status_r <= res_status_nxt;
      res_jump_r   <= res_jump_nxt;
      res_target_r <= res_target_nxt;
      res_dspc_r   <= res_dspc_nxt;
      res_wr_r     <= gpr_we;
      res_widx_r   <= gpr_we ? wr_idx : 5'd0;
      res_wval_r   <= gpr_we ? wr_val : '0;
      res_rdval_r  <= res_rdval_nxt;
    end
  end

  assign out_valid         = out_v_r;
  assign out_status        = res_status_r;
  assign out_jump_taken    = res_jump_r;
  assign out_jump_target   = res_target_r;
  assign out_delay_slot_pc = res_dspc_r;
  assign out_reg_written   = res_wr_r;
  assign out_written_index = res_widx_r;
  assign out_written_value = res_wval_r;
  assign out_read_value    = res_rdval_r;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the SPECIAL-group execute block with direct register access.
// Keeps its own copy of the register file, HI and LO, and compares every result in order.
// Depends on msae_pkg and mips_special_alu_execute.
module tb_top;

  // Command code with no operation behind it.
  localparam logic [1:0] CMD_NONE = 2'd3;
  // Function code that the block does not implement.
  localparam logic [5:0] FN_UNUSED = 6'h3f;

  localparam int RANDOM_ITEMS = 620;
  localparam int TAIL_ITEMS = 60;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] instruction;
    logic [63:0] pc;
    logic [5:0]  reg_index;
    logic [63:0] reg_value;
  } exec_request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        jump_taken;
    logic [63:0] jump_target;
    logic [63:0] delay_slot_pc;
    logic        reg_written;
    logic [4:0]  written_index;
    logic [63:0] written_value;
    logic [63:0] read_value;
  } exec_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = '0;
  logic [31:0] in_instruction = '0;
  logic [63:0] in_pc = '0;
  logic [5:0]  in_reg_index = '0;
  logic [63:0] in_reg_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic        out_jump_taken;
  logic [63:0] out_jump_target;
  logic [63:0] out_delay_slot_pc;
  logic        out_reg_written;
  logic [4:0]  out_written_index;
  logic [63:0] out_written_value;
  logic [63:0] out_read_value;

  // Shadow architectural state.
  logic [63:0] gpr_shadow [0:31];
  logic [63:0] hi_shadow;
  logic [63:0] lo_shadow;

  exec_request_t pending_requests[$];
  exec_result_t  expected_results[$];
  exec_request_t cur_req;
  exec_result_t  want;
  int            total_requests;
  int            accepted_count = 0;
  int            send_gap = 0;
  int            stall_left = 0;
  int            error_count = 0;
  int            cycle_count = 0;
  logic          calm = 1'b0;

  mips_special_alu_execute DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_instruction   (in_instruction),
    .in_pc            (in_pc),
    .in_reg_index     (in_reg_index),
    .in_reg_value     (in_reg_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_jump_taken   (out_jump_taken),
    .out_jump_target  (out_jump_target),
    .out_delay_slot_pc(out_delay_slot_pc),
    .out_reg_written  (out_reg_written),
    .out_written_index(out_written_index),
    .out_written_value(out_written_value),
    .out_read_value   (out_read_value)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [63:0] widen(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  // Retire one request against the shadow state and return the result it must produce.
  function automatic exec_result_t retire(input exec_request_t rq);
    exec_result_t res;
    logic [5:0]  fn;
    logic [4:0]  sa, rd, rt, rs;
    logic [31:0] vs, vt, v32;
    logic [63:0] dbl;
    logic        wr_en;
    logic [4:0]  wr_idx;
    logic [63:0] wr_val;
    res = '0;
    wr_en = 1'b0;
    wr_idx = '0;
    wr_val = '0;
    fn = rq.instruction[5:0];
    sa = rq.instruction[10:6];
    rd = rq.instruction[15:11];
    rt = rq.instruction[20:16];
    rs = rq.instruction[25:21];
    vs = gpr_shadow[rs][31:0];
    vt = gpr_shadow[rt][31:0];
    case (rq.command)
      msae_pkg::CMD_WRITE: begin
        if (rq.reg_index < msae_pkg::IDX_HI) begin
          wr_en = 1'b1;
          wr_idx = rq.reg_index[4:0];
          wr_val = rq.reg_value;
        end else if (rq.reg_index == msae_pkg::IDX_HI) begin
          hi_shadow = rq.reg_value;
        end else if (rq.reg_index == msae_pkg::IDX_LO) begin
          lo_shadow = rq.reg_value;
        end
      end
      msae_pkg::CMD_READ: begin
        if (rq.reg_index < msae_pkg::IDX_HI) begin
          res.read_value = gpr_shadow[rq.reg_index[4:0]];
        end else if (rq.reg_index == msae_pkg::IDX_HI) begin
          res.read_value = hi_shadow;
        end else if (rq.reg_index == msae_pkg::IDX_LO) begin
          res.read_value = lo_shadow;
        end
      end
      msae_pkg::CMD_EXEC: begin
        wr_idx = rd;
        case (fn)
          msae_pkg::FN_SLL: begin
            v32 = vt << sa;
            wr_en = 1'b1;
            wr_val = widen(v32);
          end
          msae_pkg::FN_SRL: begin
            // Bit 21 turns the logical shift into a rotate.
            dbl = {vt, vt} >> sa;
            v32 = rq.instruction[21] ? dbl[31:0] : (vt >> sa);
            wr_en = 1'b1;
            wr_val = widen(v32);
          end
          msae_pkg::FN_SRA: begin
            v32 = $signed(vt) >>> sa;
            wr_en = 1'b1;
            wr_val = widen(v32);
          end
          msae_pkg::FN_SLLV: begin
            v32 = vt << vs[4:0];
            wr_en = 1'b1;
            wr_val = widen(v32);
          end
          msae_pkg::FN_SRLV: begin
            // Bit 6 turns the variable shift into a rotate.
            dbl = {vt, vt} >> vs[4:0];
            v32 = rq.instruction[6] ? dbl[31:0] : (vt >> vs[4:0]);
            wr_en = 1'b1;
            wr_val = widen(v32);
          end
          msae_pkg::FN_JR: begin
            res.jump_taken = 1'b1;
            res.jump_target = gpr_shadow[rs];
            res.delay_slot_pc = rq.pc;
          end
          msae_pkg::FN_JALR: begin
            // The target is read before the link write, even when rd equals rs.
            res.jump_taken = 1'b1;
            res.jump_target = gpr_shadow[rs];
            res.delay_slot_pc = rq.pc;
            wr_en = 1'b1;
            wr_val = rq.pc + msae_pkg::LINK_OFFSET;
          end
          msae_pkg::FN_MOVZ: begin
            wr_en = (vt == 32'd0);
            wr_val = widen(vs);
          end
          msae_pkg::FN_MOVN: begin
            wr_en = (vt != 32'd0);
            wr_val = widen(vs);
          end
          msae_pkg::FN_BREAK: res.status = msae_pkg::ST_BREAK;
          msae_pkg::FN_MFHI: begin
            wr_en = 1'b1;
            wr_val = widen(hi_shadow[31:0]);
          end
          msae_pkg::FN_MTHI: hi_shadow = gpr_shadow[rs];
          msae_pkg::FN_MFLO: begin
            wr_en = 1'b1;
            wr_val = widen(lo_shadow[31:0]);
          end
          msae_pkg::FN_MTLO: lo_shadow = gpr_shadow[rs];
          msae_pkg::FN_ADDU: begin
            v32 = vs + vt;
            wr_en = 1'b1;
            wr_val = widen(v32);
          end
          msae_pkg::FN_SUBU: begin
            v32 = vs - vt;
            wr_en = 1'b1;
            wr_val = widen(v32);
          end
          msae_pkg::FN_AND: begin
            wr_en = 1'b1;
            wr_val = widen(vs & vt);
          end
          msae_pkg::FN_OR: begin
            wr_en = 1'b1;
            wr_val = widen(vs | vt);
          end
          msae_pkg::FN_XOR: begin
            wr_en = 1'b1;
            wr_val = widen(vs ^ vt);
          end
          msae_pkg::FN_SLT: begin
            wr_en = 1'b1;
            wr_val = {63'd0, $signed(vs) < $signed(vt)};
          end
          msae_pkg::FN_SLTU: begin
            wr_en = 1'b1;
            wr_val = {63'd0, vs < vt};
          end
          default: res.status = msae_pkg::ST_UNKNOWN;
        endcase
      end
      default: res.status = msae_pkg::ST_UNKNOWN;
    endcase
    // Register zero never takes a write.
    if (wr_en && wr_idx != 5'd0) begin
      gpr_shadow[wr_idx] = wr_val;
      res.reg_written = 1'b1;
      res.written_index = wr_idx;
      res.written_value = wr_val;
    end
    return res;
  endfunction

  function automatic logic [31:0] encode(input logic [4:0] rs, input logic [4:0] rt,
                                         input logic [4:0] rd, input logic [4:0] sa,
                                         input logic [5:0] fn);
    return {6'd0, rs, rt, rd, sa, fn};
  endfunction

  function automatic logic [5:0] pick_fn(input int k);
    case (k)
      0:  return msae_pkg::FN_SLL;
      1:  return msae_pkg::FN_SRL;
      2:  return msae_pkg::FN_SRA;
      3:  return msae_pkg::FN_SLLV;
      4:  return msae_pkg::FN_SRLV;
      5:  return msae_pkg::FN_JR;
      6:  return msae_pkg::FN_JALR;
      7:  return msae_pkg::FN_MOVZ;
      8:  return msae_pkg::FN_MOVN;
      9:  return msae_pkg::FN_BREAK;
      10: return msae_pkg::FN_MFHI;
      11: return msae_pkg::FN_MTHI;
      12: return msae_pkg::FN_MFLO;
      13: return msae_pkg::FN_MTLO;
      14: return msae_pkg::FN_ADDU;
      15: return msae_pkg::FN_SUBU;
      16: return msae_pkg::FN_AND;
      17: return msae_pkg::FN_OR;
      18: return msae_pkg::FN_XOR;
      19: return msae_pkg::FN_SLT;
      default: return msae_pkg::FN_SLTU;
    endcase
  endfunction

  // Half the picks land on a few registers so that back-to-back dependencies are frequent.
  function automatic logic [4:0] pick_reg();
    if ($urandom_range(0, 1) == 0) return 5'($urandom_range(0, 3));
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 6))
      0: return 64'd0;
      1: return '1;
      2: return 64'h0000_0000_8000_0000;
      3: return 64'h0000_0000_7fff_ffff;
      4: return widen($urandom());
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic exec_request_t random_request();
    exec_request_t rq;
    int sel;
    logic [4:0] rs;
    sel = $urandom_range(0, 99);
    rq.command = msae_pkg::CMD_EXEC;
    rq.instruction = $urandom();
    rq.pc = pick_value();
    rq.reg_index = 6'($urandom_range(0, 33));
    rq.reg_value = pick_value();
    if ($urandom_range(0, 9) == 0) rq.reg_index = 6'($urandom_range(34, 63));
    if (sel < 68) begin
      rs = pick_reg();
      rq.instruction[25:21] = rs;
      rq.instruction[20:16] = pick_reg();
      rq.instruction[15:11] = pick_reg();
      if (sel < 62) rq.instruction[5:0] = pick_fn($urandom_range(0, 20));
      if (rq.instruction[5:0] == msae_pkg::FN_JALR && $urandom_range(0, 2) == 0)
        rq.instruction[15:11] = rs;
    end else if (sel < 82) begin
      rq.command = msae_pkg::CMD_WRITE;
    end else if (sel < 96) begin
      rq.command = msae_pkg::CMD_READ;
    end else begin
      rq.command = CMD_NONE;
    end
    return rq;
  endfunction

  task automatic queue_exec(input logic [4:0] rs, input logic [4:0] rt, input logic [4:0] rd,
                            input logic [4:0] sa, input logic [5:0] fn, input logic [63:0] pc);
    exec_request_t rq;
    rq = '0;
    rq.command = msae_pkg::CMD_EXEC;
    rq.instruction = encode(rs, rt, rd, sa, fn);
    rq.pc = pc;
    pending_requests.push_back(rq);
  endtask

  task automatic queue_direct(input logic [1:0] cmd, input logic [5:0] idx,
                              input logic [63:0] val);
    exec_request_t rq;
    rq = '0;
    rq.command = cmd;
    rq.reg_index = idx;
    rq.reg_value = val;
    pending_requests.push_back(rq);
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Driver: presents queued requests, with random gaps outside the tail of the run.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(retire(cur_req));
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          cur_req = pending_requests.pop_front();
          in_command <= cur_req.command;
          in_instruction <= cur_req.instruction;
          in_pc <= cur_req.pc;
          in_reg_index <= cur_req.reg_index;
          in_reg_value <= cur_req.reg_value;
          in_valid <= 1'b1;
          if (!calm && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 6);
        end else begin
          in_valid <= 1'b0;
        end
      end
      calm <= (pending_requests.size() < TAIL_ITEMS);
    end
  end

  // Monitor: checks each accepted result and stalls the output in random bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 64'(want.status), 64'(out_status));
          check_field("jump_taken", 64'(want.jump_taken), 64'(out_jump_taken));
          check_field("jump_target", want.jump_target, out_jump_target);
          check_field("delay_slot_pc", want.delay_slot_pc, out_delay_slot_pc);
          check_field("reg_written", 64'(want.reg_written), 64'(out_reg_written));
          check_field("written_index", 64'(want.written_index), 64'(out_written_index));
          check_field("written_value", want.written_value, out_written_value);
          check_field("read_value", want.read_value, out_read_value);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 32; i++) gpr_shadow[i] = '0;
    hi_shadow = '0;
    lo_shadow = '0;

    // Directed part: operand extremes, every operation and the corner cases.
    queue_direct(msae_pkg::CMD_WRITE, 6'd1, '1);
    queue_direct(msae_pkg::CMD_WRITE, 6'd2, 64'h1234_5678_8000_001f);
    queue_direct(msae_pkg::CMD_WRITE, 6'd0, 64'hdead_beef_dead_beef);
    queue_exec(5'd0, 5'd2, 5'd3, 5'd31, msae_pkg::FN_SLL, 64'd0);
    queue_exec(5'd0, 5'd2, 5'd4, 5'd0, msae_pkg::FN_SLL, 64'd0);
    queue_exec(5'd0, 5'd1, 5'd4, 5'd1, msae_pkg::FN_SRL, 64'd0);
    queue_exec(5'd1, 5'd2, 5'd5, 5'd4, msae_pkg::FN_SRL, 64'd0);
    queue_exec(5'd0, 5'd2, 5'd6, 5'd31, msae_pkg::FN_SRA, 64'd0);
    queue_exec(5'd2, 5'd1, 5'd7, 5'd0, msae_pkg::FN_SLLV, 64'd0);
    queue_exec(5'd2, 5'd2, 5'd8, 5'd0, msae_pkg::FN_SRLV, 64'd0);
    queue_exec(5'd2, 5'd2, 5'd9, 5'd1, msae_pkg::FN_SRLV, 64'd0);
    queue_exec(5'd2, 5'd0, 5'd0, 5'd0, msae_pkg::FN_JR, 64'h0000_0000_0040_0000);
    queue_exec(5'd2, 5'd0, 5'd2, 5'd0, msae_pkg::FN_JALR, '1);
    queue_exec(5'd1, 5'd0, 5'd10, 5'd0, msae_pkg::FN_MOVZ, 64'd0);
    queue_exec(5'd1, 5'd0, 5'd11, 5'd0, msae_pkg::FN_MOVN, 64'd0);
    queue_exec(5'd0, 5'd0, 5'd0, 5'd0, msae_pkg::FN_BREAK, 64'd0);
    queue_exec(5'd1, 5'd0, 5'd0, 5'd0, msae_pkg::FN_MTHI, 64'd0);
    queue_exec(5'd0, 5'd0, 5'd11, 5'd0, msae_pkg::FN_MFHI, 64'd0);
    queue_exec(5'd7, 5'd0, 5'd0, 5'd0, msae_pkg::FN_MTLO, 64'd0);
    queue_exec(5'd0, 5'd0, 5'd12, 5'd0, msae_pkg::FN_MFLO, 64'd0);
    queue_exec(5'd1, 5'd1, 5'd13, 5'd0, msae_pkg::FN_ADDU, 64'd0);
    queue_exec(5'd0, 5'd1, 5'd14, 5'd0, msae_pkg::FN_SUBU, 64'd0);
    queue_exec(5'd1, 5'd5, 5'd15, 5'd0, msae_pkg::FN_AND, 64'd0);
    queue_exec(5'd3, 5'd5, 5'd16, 5'd0, msae_pkg::FN_OR, 64'd0);
    queue_exec(5'd1, 5'd5, 5'd17, 5'd0, msae_pkg::FN_XOR, 64'd0);
    queue_exec(5'd3, 5'd1, 5'd18, 5'd0, msae_pkg::FN_SLT, 64'd0);
    queue_exec(5'd3, 5'd1, 5'd19, 5'd0, msae_pkg::FN_SLTU, 64'd0);
    queue_exec(5'd1, 5'd2, 5'd20, 5'd0, FN_UNUSED, 64'd0);
    queue_direct(CMD_NONE, 6'd1, '1);
    queue_direct(msae_pkg::CMD_WRITE, 6'd63, '1);
    queue_direct(msae_pkg::CMD_READ, 6'd40, 64'd0);
    queue_direct(msae_pkg::CMD_READ, msae_pkg::IDX_HI, 64'd0);
    queue_direct(msae_pkg::CMD_READ, msae_pkg::IDX_LO, 64'd0);
    queue_exec(5'd0, 5'd0, 5'd0, 5'd0, msae_pkg::FN_SLL, 64'd0);

    // Random part.
    repeat (RANDOM_ITEMS) pending_requests.push_back(random_request());
    total_requests = pending_requests.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_count != total_requests) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
